// File: rtl/aspi_cs_pkg.sv
// Package: command codes, tag codes and helpers for the amplifier SPI command sequencer.
`timescale 1ns / 1ps

package aspi_cs_pkg;

	localparam int CHANNELS   = 16;
	localparam int ANSWER_LAG = 3;

	localparam int MASK_W = 16;
	localparam int CHAN_W = 4;
	localparam int TAG_W  = 8;

	// command kinds
	localparam logic [2:0] KIND_CONVERT   = 3'd0;
	localparam logic [2:0] KIND_WRITE     = 3'd1;
	localparam logic [2:0] KIND_READ      = 3'd2;
	localparam logic [2:0] KIND_CALIBRATE = 3'd3;
	localparam logic [2:0] KIND_CLEAR_CAL = 3'd4;
	localparam logic [2:0] KIND_DUMMY     = 3'd5;

	// command byte values
	localparam logic [1:0] OP_CONVERT     = 2'b00;
	localparam logic [1:0] OP_WRITE       = 2'b10;
	localparam logic [1:0] OP_READ        = 2'b11;
	localparam logic [7:0] CMD_CALIBRATE  = 8'b0101_0101;
	localparam logic [7:0] CMD_CLEAR_CAL  = 8'b0110_1010;
	localparam logic [7:0] CMD_DUMMY      = 8'hFF;

	// answer tag types
	localparam logic [1:0] TAG_NONE   = 2'd0;
	localparam logic [1:0] TAG_SAMPLE = 2'd1;
	localparam logic [1:0] TAG_READ   = 2'd2;

	// configuration register indexes
	localparam logic CFG_MASK   = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	typedef logic [TAG_W-1:0] tag_t;

	// index of the lowest set bit, 0 when none
	function automatic logic [CHAN_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
		logic [CHAN_W-1:0] res;
		res = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				res = CHAN_W'(i);
			end
		end
		return res;
	endfunction

endpackage

// File: rtl/amplifier_spi_command_sequencer.sv
// Top level: SPI command word builder with round-robin channel scan and answer tagging.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid/in_ready, kind, reg_address,           | in
//          | write_data, rx_word                             |
//  output  | out_valid/out_ready, tx_word, sample_*, read_*, | out
//          | scan_last                                       |
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data        | in
//
// One transfer per cycle sustained while out_ready is not held low; each command passes
// through the input register, then the result register.
// The channel pick is a 16-bit priority encoder on the masked active bits, evaluated
// in the cycle between the two registers together with the tag shift.
// Reset clears the scan pointer and all answer tags (none), sets every channel active
// and turns offset removal off.
// A stalled output holds both stages; the input stage is free whenever it is empty or advances.
`timescale 1ns / 1ps

module amplifier_spi_command_sequencer
	import aspi_cs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [5:0]  reg_address,
	input  logic [7:0]  write_data,
	input  logic [15:0] rx_word,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] tx_word,
	output logic        sample_valid,
	output logic [3:0]  sample_channel,
	output logic [15:0] sample_value,
	output logic        read_valid,
	output logic [5:0]  read_address,
	output logic [7:0]  read_byte,
	output logic        scan_last,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [MASK_W-1:0] mask_q;
	logic              offset_q;
	logic [CHAN_W-1:0] next_channel_q;
	tag_t              tags_q [ANSWER_LAG];

	logic              valid_s1;
	logic [2:0]        kind_s1;
	logic [5:0]        addr_s1;
	logic [7:0]        wdata_s1;
	logic [15:0]       rx_s1;

	logic              valid_s2;
	logic [15:0]       tx_s2;
	logic              sample_valid_s2;
	logic [3:0]        sample_channel_s2;
	logic [15:0]       sample_value_s2;
	logic              read_valid_s2;
	logic [5:0]        read_address_s2;
	logic [7:0]        read_byte_s2;
	logic              scan_last_s2;

	logic              advance;
	logic              in_xfer;

	logic [MASK_W-1:0] span_mask;
	logic [MASK_W-1:0] upper_mask;
	logic [MASK_W-1:0] above_mask;
	logic [CHAN_W-1:0] pick;
	logic              pick_last;
	logic [CHAN_W-1:0] pick_next;

	logic [15:0]       tx_c;
	tag_t              new_tag;
	logic              last_c;
	tag_t              old_tag;
	logic [1:0]        old_type;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign in_xfer   = in_valid && in_ready;

	// channels at or beyond CHANNELS never active
	always_comb begin
		span_mask = mask_q;
		for (int c = 0; c < MASK_W; c++) begin
			if (c >= CHANNELS) begin
				span_mask[c] = 1'b0;
			end
		end
	end

	// round-robin pick starting at next_channel_q
	always_comb begin
		upper_mask = span_mask & ({MASK_W{1'b1}} << next_channel_q);
		if (upper_mask != '0) begin
			pick = lowest_set(upper_mask);
		end else begin
			pick = lowest_set(span_mask);
		end
		above_mask = span_mask & ({{(MASK_W-1){1'b1}}, 1'b0} << pick);
		if (span_mask == '0) begin
			pick      = '0;
			pick_last = 1'b1;
		end else begin
			pick_last = (above_mask == '0);
		end
		pick_next = pick_last ? '0 : pick + CHAN_W'(1);
	end

	always_comb begin
		tx_c    = {CMD_DUMMY, 8'h00};
		new_tag = {TAG_NONE, 6'd0};
		last_c  = 1'b0;
		case (kind_s1)
			KIND_CONVERT: begin
				tx_c    = {OP_CONVERT, 2'b00, pick, 7'd0, offset_q};
				new_tag = {TAG_SAMPLE, 2'b00, pick};
				last_c  = pick_last;
			end
			KIND_WRITE: begin
				tx_c = {OP_WRITE, addr_s1, wdata_s1};
			end
			KIND_READ: begin
				tx_c    = {OP_READ, addr_s1, 8'h00};
				new_tag = {TAG_READ, addr_s1};
			end
			KIND_CALIBRATE: begin
				tx_c = {CMD_CALIBRATE, 8'h00};
			end
			KIND_CLEAR_CAL: begin
				tx_c = {CMD_CLEAR_CAL, 8'h00};
			end
			default: begin
				tx_c = {CMD_DUMMY, 8'h00};
			end
		endcase
	end

	assign old_tag  = tags_q[ANSWER_LAG-1];
	assign old_type = old_tag[7:6];

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q         <= '1;
			offset_q       <= 1'b0;
			next_channel_q <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			for (int i = 0; i < ANSWER_LAG; i++) begin
				tags_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MASK:   mask_q   <= cfg_data;
					CFG_OFFSET: offset_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				if (kind_s1 == KIND_CONVERT) begin
					next_channel_q <= pick_next;
				end
				for (int i = ANSWER_LAG - 1; i > 0; i--) begin
					tags_q[i] <= tags_q[i-1];
				end
				tags_q[0] <= new_tag;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1  <= kind;
			addr_s1  <= reg_address;
			wdata_s1 <= write_data;
			rx_s1    <= rx_word;
		end
		if (advance && valid_s1) begin
			tx_s2             <= tx_c;
			sample_valid_s2   <= (old_type == TAG_SAMPLE);
			sample_channel_s2 <= (old_type == TAG_SAMPLE) ? old_tag[3:0] : 4'd0;
			sample_value_s2   <= (old_type == TAG_SAMPLE) ? rx_s1 : 16'd0;
			read_valid_s2     <= (old_type == TAG_READ);
			read_address_s2   <= (old_type == TAG_READ) ? old_tag[5:0] : 6'd0;
			read_byte_s2      <= (old_type == TAG_READ) ? rx_s1[7:0] : 8'd0;
			scan_last_s2      <= last_c;
		end
	end

	assign out_valid      = valid_s2;
	assign tx_word        = tx_s2;
	assign sample_valid   = sample_valid_s2;
	assign sample_channel = sample_channel_s2;
	assign sample_value   = sample_value_s2;
	assign read_valid     = read_valid_s2;
	assign read_address   = read_address_s2;
	assign read_byte      = read_byte_s2;
	assign scan_last      = scan_last_s2;

endmodule
